### src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### src/ldsw_pkg.sv
`timescale 1ns / 1ps

package ldsw_pkg;

   // Number of digit bytes the block can hold.
   localparam int DIGITS = 4;
   localparam int IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   // Controller command bytes.
   localparam logic [7:0] CMD_DATA = 8'h40;
   localparam logic [7:0] CMD_ADDR = 8'hC0;
   localparam logic [7:0] CMD_CTRL = 8'h80;

   // Saturation limits of the tick counters.
   localparam logic [15:0] STEP_CNT_MAX  = 16'hFFFF;
   localparam logic [23:0] START_CNT_MAX = 24'hFFFFFF;

   // Register reset values.
   localparam logic [2:0]  RST_BRIGHTNESS = 3'd7;
   localparam logic        RST_DISPLAY_ON = 1'b1;
   localparam logic [15:0] RST_INTERVAL   = 16'd50;
   localparam logic [23:0] RST_TIMEOUT    = 24'd50000;

   // Register indexes.
   typedef logic [1:0] reg_idx_type;
   localparam reg_idx_type REG_BRIGHTNESS = 2'd0;
   localparam reg_idx_type REG_DISPLAY_ON = 2'd1;
   localparam reg_idx_type REG_INTERVAL   = 2'd2;
   localparam reg_idx_type REG_TIMEOUT    = 2'd3;

   // Input action codes.
   localparam logic ACT_TICK  = 1'b0;
   localparam logic ACT_START = 1'b1;

   // Sequence phases.
   typedef enum logic [8:0] {
      PH_DATA_CMD = 9'b000000001,
      PH_STOP_A   = 9'b000000010,
      PH_START_A  = 9'b000000100,
      PH_ADDR_CMD = 9'b000001000,
      PH_DIGITS   = 9'b000010000,
      PH_STOP_B   = 9'b000100000,
      PH_START_B  = 9'b001000000,
      PH_CTRL_CMD = 9'b010000000,
      PH_STOP_END = 9'b100000000
   } phase_type;

   typedef logic [2:0] sub_type;

   // Line steps within a byte write.
   localparam sub_type BS_CLK_LOW  = 3'd0;
   localparam sub_type BS_DATA     = 3'd1;
   localparam sub_type BS_CLK_HIGH = 3'd2;
   localparam sub_type BS_ACK_LOW  = 3'd3;
   localparam sub_type BS_ACK_REL  = 3'd4;
   localparam sub_type BS_ACK_HIGH = 3'd5;
   localparam sub_type BS_ACK_END  = 3'd6;

   // Line steps within a stop condition.
   localparam sub_type SP_CLK_LOW   = 3'd0;
   localparam sub_type SP_DATA_LOW  = 3'd1;
   localparam sub_type SP_CLK_HIGH  = 3'd2;
   localparam sub_type SP_DATA_HIGH = 3'd3;

   // Line steps within a start condition.
   localparam sub_type ST_CLK_HIGH  = 3'd0;
   localparam sub_type ST_DATA_HIGH = 3'd1;
   localparam sub_type ST_DATA_LOW  = 3'd2;

endpackage

### src/ldsw_req_if.sv
`timescale 1ns / 1ps

// Request channel: one word is either a tick or a start with its digit data.
interface ldsw_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] digit0_segments;
   logic [7:0] digit1_segments;
   logic [7:0] digit2_segments;
   logic [7:0] digit3_segments;
   logic [2:0] digit_count;
   logic [1:0] start_address;

   modport source (
      output valid, action, digit0_segments, digit1_segments, digit2_segments,
             digit3_segments, digit_count, start_address,
      input  ready
   );

   modport sink (
      input  valid, action, digit0_segments, digit1_segments, digit2_segments,
             digit3_segments, digit_count, start_address,
      output ready
   );
endinterface

### src/ldsw_rsp_if.sv
`timescale 1ns / 1ps

// Response channel: line levels and status after each request word.
interface ldsw_rsp_if;
   logic valid;
   logic ready;
   logic clock_released;
   logic data_released;
   logic busy_res;
   logic finished;
   logic timed_out;

   modport source (
      output valid, clock_released, data_released, busy_res, finished, timed_out,
      input  ready
   );

   modport sink (
      input  valid, clock_released, data_released, busy_res, finished, timed_out,
      output ready
   );
endinterface

### src/led_driver_serial_writer_top.sv
// A response word is registered at the clock edge that takes its request word.
// Throughput: one request word per cycle; the response register is the only buffer,
// so a new word is taken whenever that register is empty or is being drained.
// Reset (synchronous, active high) idles the sequencer, releases both lines,
// empties the response register and restores the register defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module led_driver_serial_writer_top (
   input  logic                     clock,
   input  logic                     reset,
   ldsw_req_if.sink                 req_bus,
   ldsw_rsp_if.source               rsp_bus,
   input  logic                     csr_we,
   input  ldsw_pkg::reg_idx_type    csr_index,
   input  logic [23:0]              csr_wdata
);
   import ldsw_pkg::*;

   // Configuration registers.
   logic [2:0]  brightness_ff;
   logic        display_on_ff;
   logic [15:0] interval_ff;
   logic [23:0] timeout_ff;

   // Sequencer state.
   phase_type   phase_ff, phase_in;
   sub_type     sub_ff, sub_in;
   logic [3:0]  bits_ff, bits_in;
   logic [7:0]  shift_ff, shift_in;
   logic [2:0]  index_ff, index_in;
   logic [2:0]  count_ff, count_in;
   logic [1:0]  address_ff, address_in;
   logic        active_ff, active_in;
   logic [15:0] since_step_ff, since_step_in;
   logic [23:0] since_start_ff, since_start_in;
   logic        clock_line_ff, clock_line_in;
   logic        data_line_ff, data_line_in;
   logic [7:0]  digit_ff [DIGITS];
   logic [7:0]  digit_in [DIGITS];

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_clock_ff, rsp_data_ff, rsp_busy_ff, rsp_fin_ff, rsp_tmo_ff;

   logic        accept;
   logic        fin, tmo;
   logic [7:0]  seg [4];
   logic [2:0]  count_clamp;
   logic [15:0] step_inc;
   logic [23:0] start_inc;
   logic [3:0]  bits_inc;
   logic [2:0]  index_inc;

   // A word is taken while the response register is free or draining.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   assign seg[0] = req_bus.digit0_segments;
   assign seg[1] = req_bus.digit1_segments;
   assign seg[2] = req_bus.digit2_segments;
   assign seg[3] = req_bus.digit3_segments;

   assign count_clamp = (req_bus.digit_count > 3'(DIGITS)) ? 3'(DIGITS)
                                                           : req_bus.digit_count;
   assign step_inc  = (since_step_ff == STEP_CNT_MAX) ? since_step_ff
                                                      : since_step_ff + 16'd1;
   assign start_inc = (since_start_ff == START_CNT_MAX) ? since_start_ff
                                                        : since_start_ff + 24'd1;
   assign bits_inc  = bits_ff + 4'd1;
   assign index_inc = index_ff + 3'd1;

   // Digit store is loaded on every start; entries past the count hold zero.
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         digit_in[i] = (3'(i) < count_clamp) ? seg[i] : 8'd0;
      end
   end

   // Next state for one request word.
   always_comb begin
      phase_in       = phase_ff;
      sub_in         = sub_ff;
      bits_in        = bits_ff;
      shift_in       = shift_ff;
      index_in       = index_ff;
      count_in       = count_ff;
      address_in     = address_ff;
      active_in      = active_ff;
      since_step_in  = since_step_ff;
      since_start_in = since_start_ff;
      clock_line_in  = clock_line_ff;
      data_line_in   = data_line_ff;
      fin            = 1'b0;
      tmo            = 1'b0;

      if (accept && req_bus.action == ACT_START) begin
         count_in       = count_clamp;
         address_in     = req_bus.start_address;
         clock_line_in  = 1'b1;
         data_line_in   = 1'b0;
         since_step_in  = 16'd0;
         since_start_in = 24'd0;
         phase_in       = PH_DATA_CMD;
         sub_in         = BS_CLK_LOW;
         bits_in        = 4'd0;
         index_in       = 3'd0;
         shift_in       = CMD_DATA;
         active_in      = 1'b1;
      end else if (accept && active_ff) begin
         since_start_in = start_inc;
         since_step_in  = step_inc;
         if (start_inc > timeout_ff) begin
            // Watchdog: go idle and leave the lines where they are.
            active_in = 1'b0;
            tmo       = 1'b1;
         end else if (step_inc >= interval_ff) begin
            since_step_in = 16'd0;
            case (phase_ff)
               // Byte writes: eight data bits LSB first, then one ack clock.
               PH_DATA_CMD, PH_ADDR_CMD, PH_DIGITS, PH_CTRL_CMD: begin
                  case (sub_ff)
                     BS_CLK_LOW: begin
                        clock_line_in = 1'b0;
                        sub_in        = BS_DATA;
                     end
                     BS_DATA: begin
                        data_line_in = shift_ff[0];
                        sub_in       = BS_CLK_HIGH;
                     end
                     BS_CLK_HIGH: begin
                        clock_line_in = 1'b1;
                        shift_in      = {1'b0, shift_ff[7:1]};
                        bits_in       = bits_inc;
                        sub_in        = (bits_inc < 4'd8) ? BS_CLK_LOW : BS_ACK_LOW;
                     end
                     BS_ACK_LOW: begin
                        clock_line_in = 1'b0;
                        sub_in        = BS_ACK_REL;
                     end
                     BS_ACK_REL: begin
                        data_line_in = 1'b1;
                        sub_in       = BS_ACK_HIGH;
                     end
                     BS_ACK_HIGH: begin
                        clock_line_in = 1'b1;
                        sub_in        = BS_ACK_END;
                     end
                     BS_ACK_END: begin
                        clock_line_in = 1'b0;
                        bits_in       = 4'd0;
                        sub_in        = BS_CLK_LOW;
                        case (phase_ff)
                           PH_DATA_CMD: phase_in = PH_STOP_A;
                           PH_ADDR_CMD: begin
                              phase_in = PH_DIGITS;
                              index_in = 3'd0;
                              shift_in = digit_ff[0];
                           end
                           PH_DIGITS: begin
                              index_in = index_inc;
                              if (index_inc >= count_ff) begin
                                 phase_in = PH_STOP_B;
                              end else begin
                                 shift_in = digit_ff[index_inc[IDX_W-1:0]];
                              end
                           end
                           PH_CTRL_CMD: phase_in = PH_STOP_END;
                           default: active_in = 1'b0;
                        endcase
                     end
                     default: active_in = 1'b0;
                  endcase
               end
               // Stop conditions: data rises while the clock is high.
               PH_STOP_A, PH_STOP_B, PH_STOP_END: begin
                  case (sub_ff)
                     SP_CLK_LOW: begin
                        clock_line_in = 1'b0;
                        sub_in        = SP_DATA_LOW;
                     end
                     SP_DATA_LOW: begin
                        data_line_in = 1'b0;
                        sub_in       = SP_CLK_HIGH;
                     end
                     SP_CLK_HIGH: begin
                        clock_line_in = 1'b1;
                        sub_in        = SP_DATA_HIGH;
                     end
                     SP_DATA_HIGH: begin
                        data_line_in = 1'b1;
                        case (phase_ff)
                           PH_STOP_A: begin
                              phase_in = PH_START_A;
                              sub_in   = ST_CLK_HIGH;
                              shift_in = CMD_ADDR + {6'd0, address_ff};
                           end
                           PH_STOP_B: begin
                              phase_in = PH_START_B;
                              sub_in   = ST_CLK_HIGH;
                              shift_in = CMD_CTRL + {4'd0, display_on_ff, brightness_ff};
                           end
                           PH_STOP_END: begin
                              active_in = 1'b0;
                              fin       = 1'b1;
                           end
                           default: active_in = 1'b0;
                        endcase
                     end
                     default: active_in = 1'b0;
                  endcase
               end
               // Start conditions: data falls while the clock is high.
               PH_START_A, PH_START_B: begin
                  case (sub_ff)
                     ST_CLK_HIGH: begin
                        clock_line_in = 1'b1;
                        sub_in        = ST_DATA_HIGH;
                     end
                     ST_DATA_HIGH: begin
                        data_line_in = 1'b1;
                        sub_in       = ST_DATA_LOW;
                     end
                     ST_DATA_LOW: begin
                        data_line_in = 1'b0;
                        sub_in       = BS_CLK_LOW;
                        phase_in     = (phase_ff == PH_START_A) ? PH_ADDR_CMD : PH_CTRL_CMD;
                     end
                     default: active_in = 1'b0;
                  endcase
               end
               default: active_in = 1'b0;
            endcase
         end
      end
   end

   // The response register fills on each taken word and empties when read.
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff  <= RST_BRIGHTNESS;
         display_on_ff  <= RST_DISPLAY_ON;
         interval_ff    <= RST_INTERVAL;
         timeout_ff     <= RST_TIMEOUT;
         phase_ff       <= PH_DATA_CMD;
         sub_ff         <= BS_CLK_LOW;
         bits_ff        <= 4'd0;
         shift_ff       <= 8'd0;
         index_ff       <= 3'd0;
         count_ff       <= 3'd0;
         address_ff     <= 2'd0;
         active_ff      <= 1'b0;
         since_step_ff  <= 16'd0;
         since_start_ff <= 24'd0;
         clock_line_ff  <= 1'b1;
         data_line_ff   <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_BRIGHTNESS: brightness_ff <= csr_wdata[2:0];
               REG_DISPLAY_ON: display_on_ff <= csr_wdata[0];
               REG_INTERVAL:   interval_ff   <= csr_wdata[15:0];
               REG_TIMEOUT:    timeout_ff    <= csr_wdata;
               default:        ;
            endcase
         end
         phase_ff       <= phase_in;
         sub_ff         <= sub_in;
         bits_ff        <= bits_in;
         shift_ff       <= shift_in;
         index_ff       <= index_in;
         count_ff       <= count_in;
         address_ff     <= address_in;
         active_ff      <= active_in;
         since_step_ff  <= since_step_in;
         since_start_ff <= since_start_in;
         clock_line_ff  <= clock_line_in;
         data_line_ff   <= data_line_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Digit store and response payload need no reset.
   always_ff @(posedge clock) begin
      if (accept && req_bus.action == ACT_START) begin
         for (int i = 0; i < DIGITS; i++) begin
            digit_ff[i] <= digit_in[i];
         end
      end
      if (accept) begin
         rsp_clock_ff <= clock_line_in;
         rsp_data_ff  <= data_line_in;
         rsp_busy_ff  <= active_in;
         rsp_fin_ff   <= fin;
         rsp_tmo_ff   <= tmo;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.clock_released = rsp_clock_ff;
   assign rsp_bus.data_released  = rsp_data_ff;
   assign rsp_bus.busy_res       = rsp_busy_ff;
   assign rsp_bus.finished       = rsp_fin_ff;
   assign rsp_bus.timed_out      = rsp_tmo_ff;

   // A stalled response word is never overwritten by a new one.
   `ASSERT_NEVER(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_bus.ready && accept, "response overwritten while stalled")
   // A start word always launches the data command.
   `ASSERT_CLK(a_start_launch, clock, reset, accept && req_bus.action == ACT_START |=> active_ff && phase_ff == PH_DATA_CMD, "start did not launch the sequence")
   // A finished or abandoned transfer reports the block as idle.
   `ASSERT_CLK(a_done_idle, clock, reset, rsp_valid_ff && (rsp_fin_ff || rsp_tmo_ff) |-> !rsp_busy_ff && !active_ff, "block busy after end of transfer")
   // A tick while idle leaves both lines alone.
   `ASSERT_CLK(a_idle_tick, clock, reset, accept && req_bus.action == ACT_TICK && !active_ff |=> $stable(clock_line_ff) && $stable(data_line_ff), "lines moved on an idle tick")

endmodule

### bench/tb_led_driver_serial_writer_top.sv
`timescale 1ns / 1ps

module tb_led_driver_serial_writer_top;
   import ldsw_pkg::*;

   // Line steps taken by one byte with its acknowledge clock, a stop and a start.
   localparam int BYTE_STEPS  = 28;
   localparam int STOP_STEPS  = 4;
   localparam int START_STEPS = 3;
   localparam int QUIET_LIMIT = 5000;
   localparam int LONG_HOLD   = 200;

   typedef struct packed {
      logic                    action;
      logic [DIGITS-1:0][7:0]  seg;
      logic [2:0]              count;
      logic [1:0]              addr;
   } ldsw_word_type;

   typedef struct packed {
      logic clk_rel;
      logic data_rel;
      logic busy;
      logic fin;
      logic tmo;
   } line_status_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   reg_idx_type csr_index;
   logic [23:0] csr_wdata;

   ldsw_req_if req_bus ();
   ldsw_rsp_if rsp_bus ();

   led_driver_serial_writer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Expected line status words, oldest first.
   line_status_type expected_lines [$];

   int unsigned fail_count;
   int unsigned words_taken;
   int unsigned starts_taken;
   int unsigned done_count;
   int unsigned expiry_count;

   bit          src_idle_on;
   bit          sink_stall_on;
   int unsigned sink_hold_req;

   // Register copies.
   logic [2:0]  cfg_brightness;
   logic        cfg_display_on;
   logic [15:0] cfg_interval;
   logic [23:0] cfg_timeout;

   // Sequencer copy.
   phase_type   seq_phase;
   sub_type     seq_sub;
   logic [3:0]  bit_cnt;
   logic [7:0]  out_byte;
   logic [2:0]  byte_idx;
   logic [7:0]  seg_store [DIGITS];
   logic [2:0]  seg_count;
   logic [1:0]  seg_addr;
   logic        seq_active;
   logic [15:0] step_cnt;
   logic [23:0] start_cnt;
   logic        clk_line;
   logic        dat_line;

   function automatic void reset_model();
      cfg_brightness = RST_BRIGHTNESS;
      cfg_display_on = RST_DISPLAY_ON;
      cfg_interval   = RST_INTERVAL;
      cfg_timeout    = RST_TIMEOUT;
      seq_phase  = PH_DATA_CMD;
      seq_sub    = BS_CLK_LOW;
      bit_cnt    = '0;
      out_byte   = '0;
      byte_idx   = '0;
      for (int i = 0; i < DIGITS; i++) seg_store[i] = '0;
      seg_count  = '0;
      seg_addr   = '0;
      seq_active = 1'b0;
      step_cnt   = '0;
      start_cnt  = '0;
      clk_line   = 1'b1;
      dat_line   = 1'b1;
   endfunction

   // One line step of a byte, LSB first, then the unsampled acknowledge clock.
   function automatic bit byte_bit_step();
      case (seq_sub)
         BS_CLK_LOW: begin
            clk_line = 1'b0;
            seq_sub  = BS_DATA;
         end
         BS_DATA: begin
            dat_line = out_byte[0];
            seq_sub  = BS_CLK_HIGH;
         end
         BS_CLK_HIGH: begin
            clk_line = 1'b1;
            out_byte = out_byte >> 1;
            bit_cnt  = bit_cnt + 4'd1;
            seq_sub  = (bit_cnt < 4'd8) ? BS_CLK_LOW : BS_ACK_LOW;
         end
         BS_ACK_LOW: begin
            clk_line = 1'b0;
            seq_sub  = BS_ACK_REL;
         end
         BS_ACK_REL: begin
            dat_line = 1'b1;
            seq_sub  = BS_ACK_HIGH;
         end
         BS_ACK_HIGH: begin
            clk_line = 1'b1;
            seq_sub  = BS_ACK_END;
         end
         BS_ACK_END: begin
            clk_line = 1'b0;
            bit_cnt  = '0;
            return 1'b1;
         end
         default: seq_active = 1'b0;
      endcase
      return 1'b0;
   endfunction

   function automatic bit stop_cond_step();
      case (seq_sub)
         SP_CLK_LOW: begin
            clk_line = 1'b0;
            seq_sub  = SP_DATA_LOW;
         end
         SP_DATA_LOW: begin
            dat_line = 1'b0;
            seq_sub  = SP_CLK_HIGH;
         end
         SP_CLK_HIGH: begin
            clk_line = 1'b1;
            seq_sub  = SP_DATA_HIGH;
         end
         SP_DATA_HIGH: begin
            dat_line = 1'b1;
            return 1'b1;
         end
         default: seq_active = 1'b0;
      endcase
      return 1'b0;
   endfunction

   function automatic bit start_cond_step();
      case (seq_sub)
         ST_CLK_HIGH: begin
            clk_line = 1'b1;
            seq_sub  = ST_DATA_HIGH;
         end
         ST_DATA_HIGH: begin
            dat_line = 1'b1;
            seq_sub  = ST_DATA_LOW;
         end
         ST_DATA_LOW: begin
            dat_line = 1'b0;
            return 1'b1;
         end
         default: seq_active = 1'b0;
      endcase
      return 1'b0;
   endfunction

   // Advances the whole write sequence by one line step; true when the final stop ends.
   function automatic bit advance_line();
      case (seq_phase)
         PH_DATA_CMD: begin
            if (byte_bit_step()) begin
               seq_phase = PH_STOP_A;
               seq_sub   = SP_CLK_LOW;
            end
         end
         PH_STOP_A: begin
            if (stop_cond_step()) begin
               seq_phase = PH_START_A;
               seq_sub   = ST_CLK_HIGH;
               out_byte  = CMD_ADDR + {6'd0, seg_addr};
            end
         end
         PH_START_A: begin
            if (start_cond_step()) begin
               seq_phase = PH_ADDR_CMD;
               seq_sub   = BS_CLK_LOW;
            end
         end
         PH_ADDR_CMD: begin
            if (byte_bit_step()) begin
               seq_phase = PH_DIGITS;
               seq_sub   = BS_CLK_LOW;
               byte_idx  = '0;
               out_byte  = seg_store[0];
            end
         end
         PH_DIGITS: begin
            if (byte_bit_step()) begin
               seq_sub  = BS_CLK_LOW;
               byte_idx = byte_idx + 3'd1;
               // A count of zero still sends the first (zero) byte.
               if (byte_idx >= seg_count) begin
                  seq_phase = PH_STOP_B;
                  seq_sub   = SP_CLK_LOW;
               end else begin
                  out_byte = seg_store[byte_idx[1:0]];
               end
            end
         end
         PH_STOP_B: begin
            if (stop_cond_step()) begin
               seq_phase = PH_START_B;
               seq_sub   = ST_CLK_HIGH;
               out_byte  = CMD_CTRL + {4'd0, cfg_display_on, cfg_brightness};
            end
         end
         PH_START_B: begin
            if (start_cond_step()) begin
               seq_phase = PH_CTRL_CMD;
               seq_sub   = BS_CLK_LOW;
            end
         end
         PH_CTRL_CMD: begin
            if (byte_bit_step()) begin
               seq_phase = PH_STOP_END;
               seq_sub   = SP_CLK_LOW;
            end
         end
         PH_STOP_END: begin
            if (stop_cond_step()) begin
               seq_active = 1'b0;
               return 1'b1;
            end
         end
         default: seq_active = 1'b0;
      endcase
      return 1'b0;
   endfunction

   // Works out the line status that one accepted request word leads to.
   function automatic line_status_type predict_lines(ldsw_word_type w);
      logic [2:0] cnt;
      logic       fin;
      logic       tmo;
      fin = 1'b0;
      tmo = 1'b0;
      if (w.action == ACT_START) begin
         cnt = (w.count > 3'(DIGITS)) ? 3'(DIGITS) : w.count;
         for (int i = 0; i < DIGITS; i++) seg_store[i] = (i < cnt) ? w.seg[i] : 8'h00;
         seg_count  = cnt;
         seg_addr   = w.addr;
         // The forced stop and start leave clock high and data low.
         clk_line   = 1'b1;
         dat_line   = 1'b0;
         step_cnt   = '0;
         start_cnt  = '0;
         seq_phase  = PH_DATA_CMD;
         seq_sub    = BS_CLK_LOW;
         bit_cnt    = '0;
         byte_idx   = '0;
         out_byte   = CMD_DATA;
         seq_active = 1'b1;
      end else if (seq_active) begin
         if (start_cnt != START_CNT_MAX) start_cnt = start_cnt + 24'd1;
         if (step_cnt != STEP_CNT_MAX) step_cnt = step_cnt + 16'd1;
         if (start_cnt > cfg_timeout) begin
            seq_active = 1'b0;
            tmo = 1'b1;
         end else if (step_cnt >= cfg_interval) begin
            step_cnt = '0;
            fin = advance_line();
         end
      end
      return '{clk_rel: clk_line, data_rel: dat_line, busy: seq_active, fin: fin, tmo: tmo};
   endfunction

   function automatic void check_field(string name, logic want, logic got);
      if (got !== want) begin
         $error("%s mismatch: expected %0b, got %0b", name, want, got);
         fail_count++;
      end
   endfunction

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Tracks register writes and accepted words, predicts and checks each result word.
   always @(posedge clock) begin : track_words
      line_status_type want;
      line_status_type got;
      ldsw_word_type   w;
      if (reset) begin
         reset_model();
         expected_lines.delete();
      end else begin
         if (csr_we === 1'b1) begin
            case (csr_index)
               REG_BRIGHTNESS: cfg_brightness = csr_wdata[2:0];
               REG_DISPLAY_ON: cfg_display_on = csr_wdata[0];
               REG_INTERVAL:   cfg_interval   = csr_wdata[15:0];
               REG_TIMEOUT:    cfg_timeout    = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got = '{clk_rel: rsp_bus.clock_released, data_rel: rsp_bus.data_released,
                    busy: rsp_bus.busy_res, fin: rsp_bus.finished, tmo: rsp_bus.timed_out};
            if (got.fin === 1'b1) done_count++;
            if (got.tmo === 1'b1) expiry_count++;
            if (expected_lines.size() == 0) begin
               $error("result word arrived with nothing expected");
               fail_count++;
            end else begin
               want = expected_lines.pop_front();
               check_field("clock_released", want.clk_rel, got.clk_rel);
               check_field("data_released", want.data_rel, got.data_rel);
               check_field("busy_res", want.busy, got.busy);
               check_field("finished", want.fin, got.fin);
               check_field("timed_out", want.tmo, got.tmo);
            end
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            w.action = req_bus.action;
            w.seg[0] = req_bus.digit0_segments;
            w.seg[1] = req_bus.digit1_segments;
            w.seg[2] = req_bus.digit2_segments;
            w.seg[3] = req_bus.digit3_segments;
            w.count  = req_bus.digit_count;
            w.addr   = req_bus.start_address;
            words_taken++;
            if (w.action == ACT_START) starts_taken++;
            expected_lines.push_back(predict_lines(w));
         end
      end
   end

   // Result side: random stalls after each word when enabled, plus long holds on request.
   initial begin : result_sink
      int unsigned stall_left;
      int unsigned hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (sink_hold_req != 0) begin
            hold_left     = sink_hold_req;
            sink_hold_req = 0;
         end
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            stall_left = sink_stall_on ? $urandom_range(0, 15) : 0;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Ends the run when no word moves on either channel for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("Timeout: no word accepted for %0d cycles", QUIET_LIMIT);
      $display("Verification failed");
      $finish;
   end

   function automatic ldsw_word_type tick_word();
      ldsw_word_type w;
      w.action = ACT_TICK;
      for (int i = 0; i < DIGITS; i++) w.seg[i] = 8'($urandom_range(0, 255));
      w.count = 3'($urandom_range(0, 7));
      w.addr  = 2'($urandom_range(0, 3));
      return w;
   endfunction

   function automatic ldsw_word_type start_word(logic [7:0] d0, logic [7:0] d1,
                                                logic [7:0] d2, logic [7:0] d3,
                                                logic [2:0] cnt, logic [1:0] addr);
      ldsw_word_type w;
      w.action = ACT_START;
      w.seg    = {d3, d2, d1, d0};
      w.count  = cnt;
      w.addr   = addr;
      return w;
   endfunction

   function automatic ldsw_word_type random_start();
      ldsw_word_type w;
      w = tick_word();
      w.action = ACT_START;
      return w;
   endfunction

   // Offers one word after a random gap and returns at the edge that takes it.
   task automatic send_word(ldsw_word_type w);
      int unsigned gap;
      gap = src_idle_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.action          <= w.action;
      req_bus.digit0_segments <= w.seg[0];
      req_bus.digit1_segments <= w.seg[1];
      req_bus.digit2_segments <= w.seg[2];
      req_bus.digit3_segments <= w.seg[3];
      req_bus.digit_count     <= w.count;
      req_bus.start_address   <= w.addr;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
   endtask

   task automatic send_ticks(int unsigned n);
      repeat (n) send_word(tick_word());
   endtask

   // Stops offering and waits until every expected word has come back.
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Writes all four registers; only called once the block has settled.
   task automatic set_config(logic [2:0] bright, logic on, logic [15:0] interval,
                             logic [23:0] limit);
      csr_we    <= 1'b1;
      csr_index <= REG_BRIGHTNESS;
      csr_wdata <= 24'(bright);
      @(posedge clock);
      csr_index <= REG_DISPLAY_ON;
      csr_wdata <= 24'(on);
      @(posedge clock);
      csr_index <= REG_INTERVAL;
      csr_wdata <= 24'(interval);
      @(posedge clock);
      csr_index <= REG_TIMEOUT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Keeps ticking until the predicted sequencer has gone idle.
   task automatic drain_to_idle();
      settle();
      while (seq_active) begin
         send_ticks(8);
         settle();
      end
   endtask

   // Sends a start and about as many ticks as the whole sequence should need.
   task automatic run_transmission(ldsw_word_type w);
      int unsigned n;
      int unsigned steps;
      n = (w.count > 3'(DIGITS)) ? DIGITS : w.count;
      if (n == 0) n = 1;
      steps = (3 + n) * BYTE_STEPS + 3 * STOP_STEPS + 2 * START_STEPS;
      send_word(w);
      send_ticks(steps * ((cfg_interval == 0) ? 1 : cfg_interval));
      drain_to_idle();
   endtask

   // Ticks straight after reset show both lines released and nothing busy.
   task automatic test_idle_after_reset();
      send_ticks(4);
      settle();
   endtask

   // Count forms, clamping, address extremes and restarts while busy.
   task automatic test_start_forms();
      set_config(3'd7, 1'b1, 16'd0, START_CNT_MAX);
      send_word(start_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd0, 2'd0));
      send_ticks(3);
      send_word(start_word(8'hA5, 8'h5A, 8'h0F, 8'hF0, 3'd5, 2'd1));
      send_ticks(2);
      send_word(start_word(8'h55, 8'hAA, 8'hC3, 8'h3C, 3'd6, 2'd2));
      send_word(start_word(8'h81, 8'h7E, 8'hFF, 8'h00, 3'd7, 2'd3));
      send_ticks(2);
      run_transmission(start_word(8'h00, 8'hFF, 8'h01, 8'h80, 3'd4, 2'd3));
      set_config(3'd0, 1'b0, 16'd1, START_CNT_MAX);
      run_transmission(start_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd0, 2'd0));
      send_ticks(3);
      settle();
   endtask

   // Watchdog expiry: at once, before any step, and in the middle of the digits.
   task automatic test_watchdog();
      set_config(3'd3, 1'b1, 16'd0, 24'd0);
      send_word(random_start());
      send_ticks(2);
      settle();
      set_config(3'd5, 1'b1, STEP_CNT_MAX, 24'd20);
      send_word(random_start());
      send_ticks(24);
      settle();
      set_config(3'd2, 1'b0, 16'd1, 24'd150);
      send_word(start_word(8'h12, 8'h34, 8'h56, 8'h78, 3'd4, 2'd1));
      send_ticks(160);
      settle();
   endtask

   // The result side holds off while words keep coming, then the sender waits it out.
   task automatic test_backpressure();
      src_idle_on   = 1'b0;
      sink_stall_on = 1'b0;
      set_config(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 16'd0, START_CNT_MAX);
      sink_hold_req = LONG_HOLD;
      send_word(random_start());
      send_ticks(60);
      settle();
      sink_stall_on = 1'b1;
      drain_to_idle();
   endtask

   // One transmission with random content and settings under random gaps
   // on both sides, sometimes after a restart part way through.
   task automatic test_random_traffic();
      logic [15:0] interval;
      logic [23:0] limit;
      src_idle_on   = 1'b1;
      sink_stall_on = 1'b1;
      interval = 16'($urandom_range(0, 2));
      limit    = ($urandom_range(0, 2) == 0) ? 24'($urandom_range(250, 900))
                                             : START_CNT_MAX;
      set_config(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), interval, limit);
      send_ticks($urandom_range(0, 3));
      if ($urandom_range(0, 2) == 0) begin
         send_word(random_start());
         send_ticks($urandom_range(1, 80));
      end
      run_transmission(random_start());
   endtask

   initial begin
      fail_count    = 0;
      words_taken   = 0;
      starts_taken  = 0;
      done_count    = 0;
      expiry_count  = 0;
      src_idle_on   = 1'b0;
      sink_stall_on = 1'b0;
      sink_hold_req = 0;
      reset                   <= 1'b1;
      csr_we                  <= 1'b0;
      csr_index               <= REG_BRIGHTNESS;
      csr_wdata               <= '0;
      req_bus.valid           <= 1'b0;
      req_bus.action          <= ACT_TICK;
      req_bus.digit0_segments <= '0;
      req_bus.digit1_segments <= '0;
      req_bus.digit2_segments <= '0;
      req_bus.digit3_segments <= '0;
      req_bus.digit_count     <= '0;
      req_bus.start_address   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_after_reset();
      test_start_forms();
      test_watchdog();
      test_backpressure();
      test_random_traffic();
      settle();

      $display("Run covered %0d request words with %0d starts, %0d completed writes",
               words_taken, starts_taken, done_count);
      $display("and %0d watchdog expiries across register extremes and channel stalls.",
               expiry_count);
      if (fail_count == 0 && expected_lines.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/ldsw_pkg.sv
src/ldsw_req_if.sv
src/ldsw_rsp_if.sv
src/led_driver_serial_writer_top.sv
bench/tb_led_driver_serial_writer_top.sv
